[src/ti_pkg.sv]
// Package for the table interpolator: shared constants and types.
// No dependencies.
package ti_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned CountW        = 9;
  localparam int unsigned IdxW          = 8;
  localparam int unsigned XW            = 32;
  localparam int unsigned YW            = 32;
  localparam int unsigned WideW         = 128;
  localparam int unsigned DivW          = 64;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_LIN   = 2'd1,
    MODE_QUAD  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_LOAD,
    ST_SETUP,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_e;

  // Divider request/response between the top level and the divider.
  typedef struct packed {
    logic             start;
    logic [WideW-1:0] num;
    logic [DivW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WideW-1:0] quo;
  } div_rsp_t;

endpackage

[src/ti_divider.sv]
// Unsigned 128 by 64 restoring divider, one quotient bit a cycle.
// Depends on ti_pkg.
module ti_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ti_pkg::div_req_t req_i,
  output ti_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(ti_pkg::WideW) + 1;

  logic                      busy_q, busy_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [ti_pkg::WideW-1:0]  num_q, num_d;
  logic [ti_pkg::DivW-1:0]   den_q, den_d;
  logic [ti_pkg::DivW-1:0]   rem_q, rem_d;
  logic                      done_q, done_d;
  logic [ti_pkg::DivW:0]     shifted;
  logic [ti_pkg::DivW:0]     diff;

  always_comb begin
    shifted = {rem_q, num_q[ti_pkg::WideW-1]};
    diff    = shifted - {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(ti_pkg::WideW);
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      // quotient bits shift into the low end as the numerator leaves the top
      if (!diff[ti_pkg::DivW]) begin
        rem_d = diff[ti_pkg::DivW-1:0];
        num_d = {num_q[ti_pkg::WideW-2:0], 1'b1};
      end else begin
        rem_d = shifted[ti_pkg::DivW-1:0];
        num_d = {num_q[ti_pkg::WideW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule

[src/table_interpolator.sv]
// Table interpolator: point memory scanned one entry a cycle, then a shared
// 128/64 divider. A query runs at most one division when linear and three when
// quadratic; an exact hit ends without any division.
// busy_o is high from the accepting edge to the result strobe. Reset (rst_ni low,
// async) clears control and sets point_count to 3; table contents undefined until written.
module table_interpolator #(
  parameter int unsigned TableDepth = ti_pkg::TableDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 mode_i,
  input  logic [ti_pkg::IdxW-1:0]    entry_index_i,
  input  logic [ti_pkg::XW-1:0]      x_value_i,
  input  logic signed [ti_pkg::YW-1:0] y_value_i,
  input  logic                       cfg_we_i,
  input  logic [ti_pkg::CountW-1:0]  cfg_wdata_i,
  output logic                       result_valid_o,
  output logic signed [ti_pkg::YW-1:0] y_result_o,
  output logic                       exact_hit_o,
  output logic                       out_of_range_o,
  output logic                       saturated_o,
  output logic [ti_pkg::IdxW-1:0]    segment_o
);

  localparam int unsigned AW  = $clog2(TableDepth);
  localparam int unsigned NW  = $clog2(TableDepth + 1);
  localparam int unsigned WW  = ti_pkg::WideW;
  localparam int unsigned XW  = ti_pkg::XW;
  localparam int unsigned YW  = ti_pkg::YW;
  localparam int unsigned PW  = 2 * XW;

  // Point memory, x and y side by side.
  logic [XW+YW-1:0] mem [TableDepth];
  logic [XW+YW-1:0] rd_q;
  logic [AW-1:0]    raddr;
  logic [XW-1:0]    rd_x;
  logic [YW-1:0]    rd_y;

  ti_pkg::state_e   state_q, state_d;
  logic [ti_pkg::CountW-1:0] cnt_cfg_q;
  logic [NW-1:0]    n_q;
  logic [1:0]       mode_q;
  logic [XW-1:0]    qx_q;
  logic [NW-1:0]    idx_q;
  logic             found_q;
  logic             hit_q, oor_q;
  logic [1:0]       ld_q;
  logic [1:0]       term_q;
  logic [AW-1:0]    base_q;
  logic [XW-1:0]    px_q [3];
  logic [YW-1:0]    py_q [3];
  logic [WW-1:0]    acc_q;
  logic [YW-1:0]    res_q;
  logic             lin_q;
  logic             zero_q;
  logic             neg_q;
  logic [PW-1:0]    ab_q, cd_q;
  logic [XW-1:0]    fa_q, fb_q, fc_q, fd_q;
  logic [YW-1:0]    mag_q;
  logic             pend_q;

  ti_pkg::div_req_t div_req;
  ti_pkg::div_rsp_t div_rsp;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_cfg_q <= ti_pkg::CountW'(3);
    else if (cfg_we_i) cnt_cfg_q <= cfg_wdata_i;
  end

  // ---- memory ----
  always_ff @(posedge clk_i) begin
    if (accept && mode_i == ti_pkg::MODE_WRITE && 32'(entry_index_i) < TableDepth) begin
      mem[AW'(entry_index_i)] <= {x_value_i, y_value_i};
    end
    rd_q <= mem[raddr];
  end
  assign rd_x = rd_q[XW+YW-1:YW];
  assign rd_y = rd_q[YW-1:0];

  // ---- helpers ----
  function automatic logic [XW-1:0] absd(input logic [XW-1:0] a, input logic [XW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // term order of the triple: i, j, k
  logic [1:0] ti, tj, tk;
  always_comb begin
    case (term_q)
      2'd0:    begin ti = 2'd0; tj = 2'd1; tk = 2'd2; end
      2'd1:    begin ti = 2'd1; tj = 2'd0; tk = 2'd2; end
      default: begin ti = 2'd2; tj = 2'd0; tk = 2'd1; end
    endcase
  end

  // repeated x in the triple drops to the upper pair; a zero-width pair
  // returns y of the lower point without a division
  logic fall_back, lin_eff, zero_span;
  assign fall_back = !lin_q && term_q == 2'd0 &&
                     (px_q[0] == px_q[1] || px_q[0] == px_q[2] || px_q[1] == px_q[2]);
  assign lin_eff   = lin_q || fall_back;
  assign zero_span = lin_eff && px_q[2] == px_q[1];

  logic [YW-1:0] yi, ymag;
  logic [YW:0]   dy;
  logic          sn_a, sn_b, sn_c, sn_d, sn_y, sn_dy;
  logic [WW-1:0] tneg;
  logic [WW-1:0] sum;
  logic [WW-1:0] yl_ext;
  logic          sat_hi, sat_lo;
  logic [NW-1:0] ucalc, minu;

  always_comb begin
    yi    = lin_q ? py_q[1] : py_q[ti];
    dy    = {py_q[2][YW-1], py_q[2]} - {py_q[1][YW-1], py_q[1]};
    sn_dy = dy[YW];
    sn_y  = yi[YW-1];
    ymag  = sn_y ? (~yi + YW'(1)) : yi;
    sn_a  = lin_eff ? (qx_q < px_q[1]) : (qx_q < px_q[tj]);
    sn_b  = qx_q < px_q[tk];
    sn_c  = px_q[ti] < px_q[tj];
    sn_d  = px_q[ti] < px_q[tk];
    tneg  = ~div_rsp.quo + WW'(1);
    yl_ext = {{(WW-YW){py_q[1][YW-1]}}, py_q[1]};
    sum   = acc_q + (neg_q ? tneg : div_rsp.quo);
    minu  = (mode_q == ti_pkg::MODE_LIN) ? NW'(1) : NW'(2);
    ucalc = found_q ? idx_q : n_q - NW'(1);
    if (ucalc < minu) ucalc = minu;
  end

  // scan address
  always_comb begin
    unique case (state_q) inside
      ti_pkg::ST_FETCH, ti_pkg::ST_LOAD: raddr = base_q + AW'(ld_q);
      default: raddr = AW'(idx_q);
    endcase
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ti_pkg::ST_IDLE:
        if (accept && (mode_i == ti_pkg::MODE_LIN || mode_i == ti_pkg::MODE_QUAD))
          state_d = ti_pkg::ST_SCAN;
      ti_pkg::ST_SCAN:
        if (pend_q && (rd_x >= qx_q || idx_q == n_q)) state_d = ti_pkg::ST_FETCH;
        else if (!pend_q && idx_q == n_q) state_d = ti_pkg::ST_FETCH;
      ti_pkg::ST_FETCH: state_d = ti_pkg::ST_LOAD;
      ti_pkg::ST_LOAD:
        if (hit_q) state_d = ti_pkg::ST_DONE;
        else if (ld_q == 2'd3) state_d = ti_pkg::ST_SETUP;
      ti_pkg::ST_SETUP: state_d = zero_span ? ti_pkg::ST_DONE : ti_pkg::ST_MUL1;
      ti_pkg::ST_MUL1:  state_d = ti_pkg::ST_MUL2;
      ti_pkg::ST_MUL2:  state_d = ti_pkg::ST_DIV;
      ti_pkg::ST_DIV:   if (div_rsp.done) state_d = ti_pkg::ST_ACC;
      ti_pkg::ST_ACC:
        if (lin_q || term_q == 2'd2) state_d = ti_pkg::ST_DONE;
        else state_d = ti_pkg::ST_SETUP;
      ti_pkg::ST_DONE:  state_d = ti_pkg::ST_IDLE;
      default:          state_d = ti_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ti_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // ---- datapath ----
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ti_pkg::ST_IDLE: begin
        if (cnt_cfg_q < ti_pkg::CountW'(3)) n_q <= NW'(3);
        else if (32'(cnt_cfg_q) > TableDepth) n_q <= NW'(TableDepth);
        else n_q <= NW'(cnt_cfg_q);
        mode_q  <= mode_i;
        qx_q    <= x_value_i;
        idx_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
        hit_q   <= 1'b0;
        oor_q   <= 1'b0;
        acc_q   <= '0;
        term_q  <= '0;
        ld_q    <= '0;
      end
      ti_pkg::ST_SCAN: begin
        // read issued for idx_q, data of idx_q-1 arrives now
        if (pend_q && rd_x >= qx_q) begin
          found_q <= 1'b1;
          idx_q   <= idx_q - NW'(1);
          hit_q   <= rd_x == qx_q;
          res_q   <= rd_y;
        end else if (idx_q != n_q) begin
          idx_q  <= idx_q + NW'(1);
          pend_q <= 1'b1;
        end
      end
      ti_pkg::ST_FETCH: begin
        base_q <= AW'(ucalc - ((mode_q == ti_pkg::MODE_LIN) ? NW'(1) : NW'(2)));
        if (!found_q) idx_q <= n_q - NW'(1);
        lin_q  <= mode_q == ti_pkg::MODE_LIN;
        ld_q   <= '0;
      end
      ti_pkg::ST_LOAD: begin
        // data of base+ld_q-1 arrives; lin pair lands in slots 1,2
        ld_q <= ld_q + 2'd1;
        if (ld_q != 2'd0) begin
          if (lin_q) begin
            if (ld_q != 2'd3) begin
              px_q[ld_q] <= rd_x;
              py_q[ld_q] <= rd_y;
            end
          end else begin
            px_q[ld_q - 2'd1] <= rd_x;
            py_q[ld_q - 2'd1] <= rd_y;
          end
        end
        if (ld_q == 2'd0) oor_q <= !found_q;
      end
      ti_pkg::ST_SETUP: begin
        if (fall_back) lin_q <= 1'b1;
        if (qx_q < px_q[0] && !lin_q) oor_q <= 1'b1;
        if (lin_q && qx_q < px_q[1]) oor_q <= 1'b1;
        if (lin_eff) begin
          fa_q   <= absd(qx_q, px_q[1]);
          fc_q   <= absd(px_q[2], px_q[1]);
          mag_q  <= sn_dy ? YW'(~dy + (YW+1)'(1)) : dy[YW-1:0];
          neg_q  <= sn_a ^ (px_q[2] < px_q[1]) ^ sn_dy;
          acc_q  <= yl_ext;
          res_q  <= py_q[1];
        end else begin
          fa_q  <= absd(qx_q, px_q[tj]);
          fb_q  <= absd(qx_q, px_q[tk]);
          fc_q  <= absd(px_q[ti], px_q[tj]);
          fd_q  <= absd(px_q[ti], px_q[tk]);
          mag_q <= ymag;
          neg_q <= sn_a ^ sn_b ^ sn_c ^ sn_d ^ sn_y;
        end
      end
      ti_pkg::ST_MUL1: begin
        if (lin_q) begin
          ab_q <= {{XW{1'b0}}, fa_q};
          cd_q <= {{XW{1'b0}}, fc_q};
        end else begin
          ab_q <= fa_q * fb_q;
          cd_q <= fc_q * fd_q;
        end
      end
      ti_pkg::ST_ACC: begin
        acc_q  <= sum;
        term_q <= term_q + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ti_pkg::ST_SETUP) zero_q <= zero_span;
  end

  // 64x32 product in two 32x32 halves, taken by the divider on leaving MUL2
  assign div_req.start = state_q == ti_pkg::ST_MUL2 && state_d == ti_pkg::ST_DIV;
  assign div_req.num   = WW'(ab_q[XW-1:0] * mag_q) + (WW'(ab_q[PW-1:XW] * mag_q) << XW);
  assign div_req.den   = cd_q;

  ti_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---- result ----
  always_comb begin
    sat_hi = (acc_q[WW-1] == 1'b0) && (acc_q[WW-2:YW-1] != '0);
    sat_lo = (acc_q[WW-1] == 1'b1) && (acc_q[WW-2:YW-1] != '1);
  end

  logic [YW-1:0] y_out;
  logic          sat_out;
  always_comb begin
    y_out   = acc_q[YW-1:0];
    sat_out = 1'b0;
    if (hit_q || zero_q) begin
      y_out = res_q;
    end else if (sat_hi) begin
      y_out = {1'b0, {(YW-1){1'b1}}};
      sat_out = 1'b1;
    end else if (sat_lo) begin
      y_out = {1'b1, {(YW-1){1'b0}}};
      sat_out = 1'b1;
    end
  end

  assign busy_o         = state_q != ti_pkg::ST_IDLE;
  assign result_valid_o = state_q == ti_pkg::ST_DONE;
  assign y_result_o     = y_out;
  assign exact_hit_o    = hit_q;
  assign out_of_range_o = hit_q ? 1'b0 : oor_q;
  assign saturated_o    = sat_out;
  assign segment_o      = ti_pkg::IdxW'(idx_q);

`ifndef NO_ASSERTIONS
  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("strobe held");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result while idle");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ti_pkg::ST_DIV) else $error("stray quotient");
`endif

endmodule
